// ----- hw/rtl/s2a_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// s2a_pkg
// Shared widths, character codes and digit helpers for the signed integer
// to ASCII converter.
// ----------------------------------------------------------------------------
package s2a_pkg;

	localparam int VALUE_BITS = 64;
	// magnitude padded to whole nibbles; four bits go into the converter per cycle
	localparam int MAG_W      = ((VALUE_BITS + 3) / 4) * 4;
	localparam int CONV_STEPS = MAG_W / 4;
	localparam int STEP_W     = $clog2(CONV_STEPS);
	localparam int NDIG       = 20;
	localparam int DIG_IDX_W  = $clog2(NDIG);

	localparam logic [7:0] CH_MINUS       = 8'h2D;
	localparam logic [7:0] CH_ZERO        = 8'h30;
	localparam logic [7:0] HEX_LETTER_OFS = 8'h37;
	localparam logic [3:0] DIGIT_TEN      = 4'hA;

	typedef logic [NDIG-1:0][3:0] digits_t;

	// one shift-and-add-3 step: adjust every BCD digit, then shift a bit in
	function automatic digits_t dabble_step(digits_t d, logic b);
		digits_t                 a;
		logic [NDIG*4-1:0]       f;
		for (int i = 0; i < NDIG; i++) begin
			a[i] = (d[i] >= 4'd5) ? (d[i] + 4'd3) : d[i];
		end
		f = a;
		f = {f[NDIG*4-2:0], b};
		return digits_t'(f);
	endfunction

	// position of the most significant nonzero digit, zero when all are zero
	function automatic logic [DIG_IDX_W-1:0] lead_index(digits_t d);
		logic [DIG_IDX_W-1:0] idx;
		idx = '0;
		for (int i = 0; i < NDIG; i++) begin
			if (d[i] != 4'd0) begin
				idx = DIG_IDX_W'(i);
			end
		end
		return idx;
	endfunction

	function automatic logic [7:0] to_ascii(logic [3:0] d, logic hex);
		logic [7:0] ext;
		ext = 8'(d);
		return (hex && d >= DIGIT_TEN) ? (ext + HEX_LETTER_OFS) : (ext + CH_ZERO);
	endfunction

endpackage

// ----- hw/rtl/signed_int_to_ascii_digits_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// signed_int_to_ascii_digits_top
// Renders a signed number as a stream of ASCII characters, decimal or hex.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) carries value and mode (0 decimal,
//   1 hexadecimal). Output channel (out_valid/out_ready) gives one character
//   per beat, most significant digit first, with a leading '-' for negative
//   numbers and last_char set on the final beat of the number.
//   Decimal: a shared shift-and-add-3 unit takes four magnitude bits per
//   cycle in the conversion loop (S_CONV); the S_SCAN state then finds the
//   leading digit, and S_EMIT sends one character per cycle while the
//   receiver is ready. Hex skips the conversion loop and goes to S_SCAN.
//   in_ready is high only while no number is being converted or emitted; the
//   next number may be taken while the final character still waits in the
//   output register.
//   A stalled receiver holds the output register and the character walk.
//   Reset clears the sequencer and the output valid; nothing else needs it.
// ----------------------------------------------------------------------------
module signed_int_to_ascii_digits_top
	import s2a_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [63:0] value,
	input  logic        mode,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [7:0]  ascii_char,
	output logic        last_char
);

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_CONV = 2'd1;
	localparam logic [1:0] S_SCAN = 2'd2;
	localparam logic [1:0] S_EMIT = 2'd3;

	logic [1:0]            state_q;
	logic [STEP_W-1:0]     step_q;
	logic [MAG_W-1:0]      sh_q;
	digits_t               digits_q;
	logic [DIG_IDX_W-1:0]  idx_q;
	logic                  sign_q;
	logic                  hex_q;
	logic                  out_valid_q;
	logic [7:0]            char_q;
	logic                  last_q;

	logic [VALUE_BITS-1:0] raw;
	logic [VALUE_BITS-1:0] mag;
	logic [MAG_W-1:0]      mag_pad;
	logic                  neg;
	digits_t               dab;
	logic [3:0]            nib;
	logic                  in_fire;
	logic                  out_load;
	logic                  dec_ok;

	assign raw     = value[VALUE_BITS-1:0];
	assign neg     = raw[VALUE_BITS-1];
	assign mag     = neg ? (~raw + 1'b1) : raw;
	assign mag_pad = MAG_W'(mag);

	assign in_ready = (state_q == S_IDLE);
	assign in_fire  = in_valid && in_ready;
	assign out_load = (state_q == S_EMIT) && (!out_valid_q || out_ready);

	// four dabble steps on the top nibble of the shifter
	always_comb begin
		nib = sh_q[MAG_W-1 -: 4];
		dab = digits_q;
		for (int b = 3; b >= 0; b--) begin
			dab = dabble_step(dab, nib[b]);
		end
	end

	always_comb begin
		dec_ok = 1'b1;
		for (int i = 0; i < NDIG; i++) begin
			if (digits_q[i] >= DIGIT_TEN) begin
				dec_ok = 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_fire) begin
						state_q <= mode ? S_SCAN : S_CONV;
					end
				end
				S_CONV: begin
					if (step_q == STEP_W'(CONV_STEPS - 1)) begin
						state_q <= S_SCAN;
					end
				end
				S_SCAN: begin
					state_q <= S_EMIT;
				end
				S_EMIT: begin
					if (out_load && !sign_q && idx_q == '0) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (in_fire) begin
					sign_q   <= neg;
					hex_q    <= mode;
					step_q   <= '0;
					sh_q     <= mag_pad;
					digits_q <= mode ? digits_t'((NDIG*4)'(mag_pad)) : '0;
				end
			end
			S_CONV: begin
				digits_q <= dab;
				sh_q     <= sh_q << 4;
				step_q   <= step_q + 1'b1;
			end
			S_SCAN: begin
				idx_q <= lead_index(digits_q);
			end
			S_EMIT: begin
				// walk down one digit per beat once the sign is out
				if (out_load) begin
					if (sign_q) begin
						sign_q <= 1'b0;
					end else if (idx_q != '0) begin
						idx_q <= idx_q - 1'b1;
					end
				end
			end
			default: begin
				step_q <= step_q;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			if (sign_q) begin
				char_q <= CH_MINUS;
				last_q <= 1'b0;
			end else begin
				char_q <= to_ascii(digits_q[idx_q], hex_q);
				last_q <= (idx_q == '0);
			end
		end
	end

	assign out_valid  = out_valid_q;
	assign ascii_char = char_q;
	assign last_char  = last_q;

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire |=> !in_ready)
		else $error("input taken while a number is in flight");

	a_step_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_CONV) |-> (step_q <= STEP_W'(CONV_STEPS - 1)))
		else $error("conversion step counter ran past the last nibble");

	a_bcd_digits: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_EMIT && !hex_q) |-> dec_ok)
		else $error("decimal digit register holds a digit above nine");

	a_sign_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> !(last_q && char_q == CH_MINUS))
		else $error("minus sign marked as the final character");

endmodule
